[design/bsst_pkg.sv]
// Shared constants, codes and control types for the band stretch threshold block.
package bsst_pkg;

    // Field and accumulator widths
    localparam int PIX_W    = 16;
    localparam int BAND_W   = 2;
    localparam int CNT_W    = 40;
    localparam int SUM_W    = 56;
    localparam int SQS_W    = 64;
    localparam int THR_W    = 25;
    localparam int SCALE_W  = 16;
    localparam int BC_W     = 3;
    localparam int CFG_IX_W = 1;

    // Iterative unit widths
    localparam int MUL_W    = 128;
    localparam int D_W      = 104;
    localparam int RAD_W    = 120;
    localparam int ROOT_W   = 60;
    localparam int SQ_REM_W = 62;
    localparam int SQ_CNT_W = 6;
    localparam int SQ_STEPS = 60;
    localparam int DEV_W    = 76;
    localparam int MAG_W    = 77;
    localparam int NUM_W    = 80;
    localparam int DV_W     = 57;
    localparam int DIV_CNT_W = 7;
    localparam int DIV_STEPS = 80;

    // Defaults
    localparam int DEF_BANDS      = 4;
    localparam int DEF_PIXEL_BITS = 16;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd640;
    localparam logic [BC_W-1:0]    BC_RESET    = 3'd1;

    localparam logic [THR_W-1:0] THR_POS_MAX = 25'd16777215;
    localparam logic [THR_W-1:0] THR_NEG_MAG = 25'd16777216;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_SCALE      = 1'b0;
    localparam logic [CFG_IX_W-1:0] CFG_BAND_COUNT = 1'b1;

    // Action and result kind codes
    localparam logic ACT_ACCUM  = 1'b0;
    localparam logic ACT_REPORT = 1'b1;
    localparam logic KIND_PAIR  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // Operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MOP_NQ  = 2'd0,
        MOP_SS  = 2'd1,
        MOP_DEV = 2'd2
    } t_mul_op;

    typedef struct packed {
        logic              acc;
        logic              load_err;
        logic              mul_start;
        t_mul_op           mul_op;
        logic              sqrt_start;
        logic              div_start;
        logic              div_low;
        logic              load_pair;
        logic [BAND_W-1:0] band;
    } t_cmd;

    typedef struct packed {
        logic band_ok;
        logic band_empty;
        logic last_band;
        logic out_free;
        logic mul_done;
        logic sqrt_done;
        logic div_done;
    } t_status;

endpackage

[design/bsst_ctrl.sv]
// Controller state machine: accepts items and sequences the report per band.
module bsst_ctrl
    import bsst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_action,
    input  logic [BAND_W-1:0] i_band,
    output logic              o_ready,
    input  t_status           i_status,
    output t_cmd              o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_START   = 9'b000000010,
        ST_MUL_NQ  = 9'b000000100,
        ST_MUL_SS  = 9'b000001000,
        ST_SQRT    = 9'b000010000,
        ST_MUL_DEV = 9'b000100000,
        ST_DIV_HI  = 9'b001000000,
        ST_DIV_LO  = 9'b010000000,
        ST_EMIT    = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [BAND_W-1:0] r_band, n_band;
    logic              accept;

    assign o_ready = (r_state == ST_IDLE) && i_status.out_free;
    assign accept  = i_valid && o_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_band  = r_band;
        o_cmd   = '0;
        o_cmd.mul_op = MOP_NQ;
        o_cmd.band   = (r_state == ST_IDLE) ? i_band : r_band;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_REPORT) begin
                        n_band  = '0;
                        n_state = ST_START;
                    end else if (i_status.band_ok) begin
                        o_cmd.acc = 1'b1;
                    end else begin
                        o_cmd.load_err = 1'b1;
                    end
                end
            end
            ST_START: begin
                if (i_status.band_empty) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = MOP_NQ;
                    n_state         = ST_MUL_NQ;
                end
            end
            ST_MUL_NQ: begin
                if (i_status.mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = MOP_SS;
                    n_state         = ST_MUL_SS;
                end
            end
            ST_MUL_SS: begin
                if (i_status.mul_done) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state          = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (i_status.sqrt_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = MOP_DEV;
                    n_state         = ST_MUL_DEV;
                end
            end
            ST_MUL_DEV: begin
                if (i_status.mul_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV_HI;
                end
            end
            ST_DIV_HI: begin
                if (i_status.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_low   = 1'b1;
                    n_state         = ST_DIV_LO;
                end
            end
            ST_DIV_LO: begin
                if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_pair = 1'b1;
                    if (i_status.last_band) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_band  = r_band + 1'b1;
                        n_state = ST_START;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_band  <= '0;
        end else begin
            r_state <= n_state;
            r_band  <= n_band;
        end
    end

endmodule

[design/bsst_dp.sv]
// Datapath: band accumulators, config registers, serial multiply, root and divide, result register.
module bsst_dp
    import bsst_pkg::*;
#(
    parameter int BANDS      = DEF_BANDS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IX_W-1:0]        i_cfg_index,
    input  logic [SCALE_W-1:0]         i_cfg_data,
    input  logic [PIX_W-1:0]           i_pixel_value,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    input  logic                       i_ready,
    output logic                       o_valid,
    output logic                       o_kind,
    output logic [BAND_W-1:0]          o_result_band,
    output logic signed [THR_W-1:0]    o_low_threshold,
    output logic signed [THR_W-1:0]    o_high_threshold,
    output logic                       o_empty_band,
    output logic                       o_last
);

    localparam int IW  = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int LIM = (BANDS < 4) ? BANDS : 4;

    // Configuration
    logic [SCALE_W-1:0] r_scale;
    logic [BC_W-1:0]    r_band_count;
    logic [BC_W-1:0]    n_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale      <= SCALE_RESET;
            r_band_count <= BC_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SCALE) begin
                r_scale <= i_cfg_data;
            end else if (i_cfg_index == CFG_BAND_COUNT) begin
                r_band_count <= i_cfg_data[BC_W-1:0];
            end
        end
    end

    // Bands in use, clamped to 1 .. LIM
    always_comb begin
        if (r_band_count == '0) begin
            n_use = BC_W'(1);
        end else if (r_band_count > BC_W'(LIM)) begin
            n_use = BC_W'(LIM);
        end else begin
            n_use = r_band_count;
        end
    end

    // Band accumulators
    logic [CNT_W-1:0] r_cnt [BANDS];
    logic [SUM_W-1:0] r_sum [BANDS];
    logic [SQS_W-1:0] r_sqs [BANDS];

    logic [IW+1:0]      band_ext;
    logic [IW-1:0]      idx;
    logic [CNT_W-1:0]   cur_n;
    logic [SUM_W-1:0]   cur_s;
    logic [SQS_W-1:0]   cur_q;
    logic [PIX_W-1:0]   pix;
    logic [2*PIX_W-1:0] pix_sq;
    logic [SUM_W:0]     sum_t;
    logic [SQS_W:0]     sqs_t;

    assign band_ext = (IW+2)'(i_cmd.band);
    assign idx      = band_ext[IW-1:0];
    assign cur_n    = r_cnt[idx];
    assign cur_s    = r_sum[idx];
    assign cur_q    = r_sqs[idx];
    assign pix      = PIX_W'(i_pixel_value[PIXEL_BITS-1:0]);
    assign pix_sq   = pix * pix;
    assign sum_t    = {1'b0, cur_s} + (SUM_W+1)'(pix);
    assign sqs_t    = {1'b0, cur_q} + (SQS_W+1)'(pix_sq);

    // Saturating update of one band; zero pixels add nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BANDS; b++) begin
                r_cnt[b] <= '0;
                r_sum[b] <= '0;
                r_sqs[b] <= '0;
            end
        end else if (i_cmd.acc && (pix != '0)) begin
            if (cur_n != '1) begin
                r_cnt[idx] <= cur_n + 1'b1;
            end
            r_sum[idx] <= sum_t[SUM_W] ? '1 : sum_t[SUM_W-1:0];
            r_sqs[idx] <= sqs_t[SQS_W] ? '1 : sqs_t[SQS_W-1:0];
        end
    end

    // Shift-add multiplier, one multiplier bit per cycle
    logic [MUL_W-1:0] r_ma, r_mp;
    logic [SQS_W-1:0] r_mb;
    logic             r_mul_busy, r_mul_done;
    t_mul_op          r_mop;
    logic [D_W-1:0]   r_nq;
    logic [ROOT_W-1:0] r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_busy <= 1'b0;
            r_mul_done <= 1'b0;
        end else begin
            r_mul_done <= 1'b0;
            if (i_cmd.mul_start) begin
                r_mul_busy <= 1'b1;
            end else if (r_mul_busy && (r_mb == '0)) begin
                r_mul_busy <= 1'b0;
                r_mul_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_mop <= i_cmd.mul_op;
            r_mp  <= '0;
            case (i_cmd.mul_op)
                MOP_NQ: begin
                    r_ma <= MUL_W'(cur_n);
                    r_mb <= cur_q;
                end
                MOP_SS: begin
                    r_ma <= MUL_W'(cur_s);
                    r_mb <= SQS_W'(cur_s);
                end
                default: begin
                    r_ma <= MUL_W'(r_root);
                    r_mb <= SQS_W'(r_scale);
                end
            endcase
        end else if (r_mul_busy && (r_mb != '0)) begin
            if (r_mb[0]) begin
                r_mp <= r_mp + r_ma;
            end
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
        end
        if (r_mul_done && (r_mop == MOP_NQ)) begin
            r_nq <= r_mp[D_W-1:0];
        end
    end

    // Variance term N*Q - S*S, floored at zero
    logic [111:0] nq_ext, ss;
    logic [111:0] d_full;
    assign nq_ext = 112'(r_nq);
    assign ss     = r_mp[111:0];
    assign d_full = (nq_ext >= ss) ? (nq_ext - ss) : '0;

    // Restoring square root, two radicand bits per cycle
    logic [RAD_W-1:0]    r_rad;
    logic [SQ_REM_W-1:0] r_rem;
    logic [SQ_CNT_W-1:0] r_sq_cnt;
    logic                r_sq_busy, r_sq_done;
    logic [63:0]         sq_tmp, sq_trial;

    assign sq_tmp   = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign sq_trial = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
            r_sq_done <= 1'b0;
        end else begin
            r_sq_done <= 1'b0;
            if (i_cmd.sqrt_start) begin
                r_sq_busy <= 1'b1;
            end else if (r_sq_busy && (r_sq_cnt == SQ_CNT_W'(SQ_STEPS - 1))) begin
                r_sq_busy <= 1'b0;
                r_sq_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_rad    <= {d_full[D_W-1:0], 16'h0000};
            r_rem    <= '0;
            r_root   <= '0;
            r_sq_cnt <= '0;
        end else if (r_sq_busy) begin
            r_rad    <= r_rad << 2;
            r_sq_cnt <= r_sq_cnt + 1'b1;
            if (sq_tmp >= sq_trial) begin
                r_rem  <= SQ_REM_W'(sq_tmp - sq_trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= sq_tmp[SQ_REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Restoring divide for round(mag / den), one quotient bit per cycle
    logic [MAG_W-1:0]     base, dev, mag;
    logic                 base_ge;
    logic [NUM_W-1:0]     r_num;
    logic [DV_W-1:0]      r_dv, r_drem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 r_div_busy, r_div_done, r_neg, r_div_low;
    logic [DV_W:0]        div_tmp;

    assign base    = MAG_W'({cur_s, 16'h0000});
    assign dev     = MAG_W'(r_mp[DEV_W-1:0]);
    assign base_ge = (base >= dev);
    assign div_tmp = {r_drem, r_num[NUM_W-1]};

    always_comb begin
        if (!i_cmd.div_low) begin
            mag = base + dev;
        end else if (base_ge) begin
            mag = base - dev;
        end else begin
            mag = dev - base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_done <= 1'b0;
        end else begin
            r_div_done <= 1'b0;
            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
            end else if (r_div_busy && (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1))) begin
                r_div_busy <= 1'b0;
                r_div_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_num     <= (NUM_W'(mag) << 1) + NUM_W'({cur_n, 16'h0000});
            r_dv      <= {cur_n, 17'h00000};
            r_drem    <= '0;
            r_div_cnt <= '0;
            r_div_low <= i_cmd.div_low;
            r_neg     <= i_cmd.div_low && !base_ge;
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt + 1'b1;
            if (div_tmp >= (DV_W+1)'(r_dv)) begin
                r_drem <= DV_W'(div_tmp - (DV_W+1)'(r_dv));
                r_num  <= {r_num[NUM_W-2:0], 1'b1};
            end else begin
                r_drem <= div_tmp[DV_W-1:0];
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
            end
        end
    end

    // Saturate the rounded quotient and apply the sign
    logic [THR_W-1:0] lim, sat_mag, thr_val;
    logic [THR_W-1:0] r_lo_thr, r_hi_thr;

    assign lim     = r_neg ? THR_NEG_MAG : THR_POS_MAX;
    assign sat_mag = (r_num > NUM_W'(lim)) ? lim : r_num[THR_W-1:0];
    assign thr_val = r_neg ? (~sat_mag + 1'b1) : sat_mag;

    always_ff @(posedge i_clk) begin
        if (r_div_done) begin
            if (r_div_low) begin
                r_lo_thr <= thr_val;
            end else begin
                r_hi_thr <= thr_val;
            end
        end
    end

    // Result register
    logic out_free;
    assign out_free = !o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.load_err || i_cmd.load_pair) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_err) begin
            o_kind           <= KIND_ERROR;
            o_result_band    <= i_cmd.band;
            o_low_threshold  <= '0;
            o_high_threshold <= '0;
            o_empty_band     <= 1'b0;
            o_last           <= 1'b1;
        end else if (i_cmd.load_pair) begin
            o_kind           <= KIND_PAIR;
            o_result_band    <= i_cmd.band;
            o_empty_band     <= (cur_n == '0);
            o_last           <= o_status.last_band;
            if (cur_n == '0) begin
                o_low_threshold  <= '0;
                o_high_threshold <= '0;
            end else begin
                o_low_threshold  <= r_lo_thr;
                o_high_threshold <= r_hi_thr;
            end
        end
    end

    // Status back to the controller
    always_comb begin
        o_status.band_ok    = ({1'b0, i_cmd.band} < n_use);
        o_status.band_empty = (cur_n == '0);
        o_status.last_band  = (({1'b0, i_cmd.band} + 1'b1) == n_use);
        o_status.out_free   = out_free;
        o_status.mul_done   = r_mul_done;
        o_status.sqrt_done  = r_sq_done;
        o_status.div_done   = r_div_done;
    end

endmodule

[design/band_stddev_stretch_thresholds.sv]
// Top level of the per-band standard deviation stretch threshold block.
//
// Input channel (i_valid / o_ready): one item is a pixel to accumulate
// (action 0) or a report request (action 1). A nonzero pixel for a band
// in use is folded into that band's saturating count, sum and square sum
// in the accepting cycle, so pixels stream at one item per cycle outside a
// report. A pixel for a band not in use gives one error item and changes
// nothing. A report gives one threshold item per band in use, the last one
// flagged. Each nonempty band runs a serial shift-add multiplier (one bit
// per cycle) for N*Q and S*S, a 60-step square root, the multiplier for
// root*scale and an 80-step divider once per threshold; empty bands skip
// these. Results sit in an output register (o_valid / i_ready); while it
// is full and not taken, new results and new items wait. Synchronous
// active-low reset clears all band accumulators, restores scale = 2.5 and
// band_count = 1, and empties the output register. Configuration writes
// (i_cfg_we) take effect at once and are meant for idle periods.
module band_stddev_stretch_thresholds
    import bsst_pkg::*;
#(
    parameter int BANDS      = DEF_BANDS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IX_W-1:0]     i_cfg_index,
    input  logic [SCALE_W-1:0]      i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_action,
    input  logic [BAND_W-1:0]       i_band,
    input  logic [PIX_W-1:0]        i_pixel_value,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_kind,
    output logic [BAND_W-1:0]       o_result_band,
    output logic signed [THR_W-1:0] o_low_threshold,
    output logic signed [THR_W-1:0] o_high_threshold,
    output logic                    o_empty_band,
    output logic                    o_last
);

    t_cmd    cmd;
    t_status status;

    bsst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_band   (i_band),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    bsst_dp #(
        .BANDS      (BANDS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_pixel_value    (i_pixel_value),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_result_band    (o_result_band),
        .o_low_threshold  (o_low_threshold),
        .o_high_threshold (o_high_threshold),
        .o_empty_band     (o_empty_band),
        .o_last           (o_last)
    );

endmodule
